@@ sv/sptx_pkg.sv @@
// ============================================================================
// sptx_pkg: shared types and constants for the serial transmit status core
// Item layouts, action codes, config indexes and frame length helper.
// ============================================================================
package sptx_pkg;

    localparam int unsigned DataW      = 16;
    localparam int unsigned ElapsedW   = 16;
    localparam int unsigned WordW      = 10;
    localparam int unsigned PeriodW    = 14;
    localparam int unsigned CountW     = 18;
    localparam int unsigned CfgIdxW    = 8;
    localparam int unsigned CfgDataW   = 16;
    localparam int unsigned InTdataW   = 40;   // 33 payload bits padded to bytes
    localparam int unsigned OutTdataW  = 32;   // 28 payload bits padded to bytes

    typedef enum logic [1:0] {
        ACT_READ_STATUS = 2'd0,
        ACT_WRITE_DATA  = 2'd1,
        ACT_END_OF_LINE = 2'd2,
        ACT_IRQ_UPDATE  = 2'd3
    } t_action;

    localparam logic [CfgIdxW-1:0] CFG_BIT_PERIOD = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_MODE  = 8'd1;

    // status word bit positions
    localparam int unsigned ST_SHIFT_EMPTY = 12;
    localparam int unsigned ST_HOLD_EMPTY  = 13;
    localparam int unsigned ST_RX_FULL     = 14;

    typedef struct packed {
        logic               long_mode;
        logic [PeriodW-1:0] bit_period;
    } t_cfg;

    typedef struct packed {
        t_action             action;
        logic [DataW-1:0]    data_word;
        logic [ElapsedW-1:0] elapsed_cycles;
        logic                rbf_request;
    } t_in_item;

    typedef struct packed {
        logic [DataW-1:0] read_word;
        logic             tbe_interrupt;
        logic             tx_start;
        logic [WordW-1:0] tx_word;
    } t_out_item;

    // engine status seen by the top level checks
    typedef struct packed {
        logic shift_empty;
        logic count_zero;
    } t_eng_status;

    // (period + 1) * 10 or 11, built from shifts and adds
    function automatic logic [CountW-1:0] frame_cycles(input t_cfg cfg);
        logic [CountW-1:0] x;
        begin
            x = {{(CountW-PeriodW){1'b0}}, cfg.bit_period} + 18'd1;
            frame_cycles = (x << 3) + (x << 1) + (cfg.long_mode ? x : 18'd0);
        end
    endfunction

endpackage

@@ sv/sptx_engine.sv @@
// ============================================================================
// sptx_engine: transmit buffer, shifter and countdown state
// Applies one item per step and produces its result combinationally.
// ============================================================================
module sptx_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  sptx_pkg::t_in_item   i_item,
    input  sptx_pkg::t_cfg       i_cfg,
    output sptx_pkg::t_out_item  o_result,
    output sptx_pkg::t_eng_status o_status
);

    logic [sptx_pkg::WordW-1:0]  r_holding,  n_holding;
    logic [sptx_pkg::WordW-1:0]  r_shifter,  n_shifter;
    logic                        r_hold_empty, n_hold_empty;
    logic                        r_shift_empty, n_shift_empty;
    logic [sptx_pkg::CountW-1:0] r_count,    n_count;
    logic                        r_rx_full,  n_rx_full;

    logic [sptx_pkg::CountW-1:0] elapsed_ext;
    logic [sptx_pkg::CountW-1:0] count_dec;
    logic [sptx_pkg::DataW-1:0]  status_word;
    logic                        moved;

    assign elapsed_ext = {{(sptx_pkg::CountW-sptx_pkg::ElapsedW){1'b0}}, i_item.elapsed_cycles};
    // saturating decrement
    assign count_dec   = (r_count > elapsed_ext) ? (r_count - elapsed_ext) : '0;

    always_comb begin
        n_holding     = r_holding;
        n_shifter     = r_shifter;
        n_hold_empty  = r_hold_empty;
        n_shift_empty = r_shift_empty;
        n_count       = r_count;
        n_rx_full     = r_rx_full;
        status_word   = '0;
        moved         = 1'b0;

        unique case (i_item.action)
            sptx_pkg::ACT_READ_STATUS: begin
                status_word[sptx_pkg::ST_SHIFT_EMPTY] = r_shift_empty;
                status_word[sptx_pkg::ST_HOLD_EMPTY]  = r_hold_empty;
                status_word[sptx_pkg::ST_RX_FULL]     = r_rx_full;
            end
            sptx_pkg::ACT_WRITE_DATA: begin
                n_holding    = i_item.data_word[sptx_pkg::WordW-1:0];
                n_hold_empty = 1'b0;
                // nonzero word goes straight to an idle shifter
                if (n_holding != '0 && r_shift_empty) begin
                    moved = 1'b1;
                end
            end
            sptx_pkg::ACT_END_OF_LINE: begin
                if (!r_shift_empty) begin
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        n_shift_empty = 1'b1;
                        moved         = !r_hold_empty;
                    end
                end
            end
            sptx_pkg::ACT_IRQ_UPDATE: begin
                n_rx_full = i_item.rbf_request;
            end
            default: ;
        endcase

        if (moved) begin
            n_shifter     = n_holding;
            n_shift_empty = 1'b0;
            n_hold_empty  = 1'b1;
            n_count       = sptx_pkg::frame_cycles(i_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding     <= '0;
            r_shifter     <= '0;
            r_hold_empty  <= 1'b1;
            r_shift_empty <= 1'b1;
            r_count       <= '0;
            r_rx_full     <= 1'b0;
        end else if (i_step) begin
            r_holding     <= n_holding;
            r_shifter     <= n_shifter;
            r_hold_empty  <= n_hold_empty;
            r_shift_empty <= n_shift_empty;
            r_count       <= n_count;
            r_rx_full     <= n_rx_full;
        end
    end

    assign o_result.read_word     = status_word;
    assign o_result.tbe_interrupt = moved;
    assign o_result.tx_start      = moved;
    assign o_result.tx_word       = n_shifter;

    assign o_status.shift_empty = r_shift_empty;
    assign o_status.count_zero  = (r_count == '0);

endmodule

@@ sv/serial_port_transmit_status_core.sv @@
// ============================================================================
// serial_port_transmit_status_core: serial transmit buffer and status block
// Double-buffered transmitter flags, countdown and status word, one item per
// cycle when the m side is not stalled, through an input and a result register.
// ============================================================================
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  s (items) | in        | i_s_tvalid/o_s_tready  | tuser action, tdata fields
//  m (result)| out       | o_m_tvalid/i_m_tready  | tdata result fields
//  cfg       | in        | i_cfg_valid/o_cfg_ready| index + data, always ready
//
//  An accepted item passes through the input register, then the result register;
//  one item per cycle sustained while the m side is not stalled.
//  Reset (synchronous, i_rst_n low) empties both stages; flags back to empty.
//  A stall on the m side holds the result register; the input register
//  still takes one item, then o_s_tready drops until the result moves.
//  Config writes are taken every cycle and land the next edge.
//
module serial_port_transmit_status_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [1:0]                         i_s_tuser,  // [1:0] action
    // [15:0] data_word, [31:16] elapsed_cycles, [32] rbf_request, rest zero
    input  logic [sptx_pkg::InTdataW-1:0]      i_s_tdata,
    // result output
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] read_word, [16] tbe_interrupt, [17] tx_start, [27:18] tx_word
    output logic [sptx_pkg::OutTdataW-1:0]     o_m_tdata,
    // config writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sptx_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [sptx_pkg::CfgDataW-1:0]      i_cfg_data
);

    // config registers
    sptx_pkg::t_cfg       r_cfg;

    // input stage
    logic                 r_in_valid;
    sptx_pkg::t_in_item   r_in;

    // result stage
    logic                 r_out_valid;
    sptx_pkg::t_out_item  r_out;

    sptx_pkg::t_out_item   eng_result;
    sptx_pkg::t_eng_status eng_status;

    logic advance;   // result register free to take the input stage
    logic step;      // input stage item is applied this cycle

    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    assign o_cfg_ready = 1'b1;

    // out-of-range indexes fall through untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == sptx_pkg::CFG_BIT_PERIOD) begin
                r_cfg.bit_period <= i_cfg_data[sptx_pkg::PeriodW-1:0];
            end else if (i_cfg_index == sptx_pkg::CFG_LONG_MODE) begin
                r_cfg.long_mode <= i_cfg_data[0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.action         <= sptx_pkg::t_action'(i_s_tuser);
            r_in.data_word      <= i_s_tdata[15:0];
            r_in.elapsed_cycles <= i_s_tdata[31:16];
            r_in.rbf_request    <= i_s_tdata[32];
        end
    end

    sptx_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (eng_result),
        .o_status (eng_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= eng_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(sptx_pkg::OutTdataW-28){1'b0}},
                         r_out.tx_word, r_out.tx_start, r_out.tbe_interrupt,
                         r_out.read_word};

    // ---------------------------------------------------------------- checks

    // busy shifter always has time left; an idle one has a cleared countdown
    a_count_tracks_shifter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_status.shift_empty == eng_status.count_zero)
        else $error("countdown out of step with shifter state");

    // a full pipeline under stall must push back on the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while both stages are held");

    // status word only ever carries the three flag bits
    a_status_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.read_word[15] == 1'b0 && r_out.read_word[11:0] == 12'd0))
        else $error("status word has bits outside the flag field");

    // an item applied with the result stage free shows up as a result next cycle
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_m_tvalid)
        else $error("applied item did not reach the result register");

endmodule
